FILE: sv/epoch_seconds_to_civil_date_assert.svh
// ---------------------------------------------------------------------------
// epoch seconds to civil date: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_ASSERT_SVH

// condition must hold at every edge
`define ESC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/esc_pkg.sv
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and tables of the epoch to civil date converter.
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int NumStages = 8;

    // per-stage load enables, driven by the valid chain in the top level
    typedef struct packed {
        logic [NumStages:1] adv;
    } t_pipe_ctl;

    // seconds split: offset input is u = t + 2^31, q = floor(u / 86400)
    localparam logic [25:0] DayRecip   = 26'd50903317;  // ceil(2^35 / 675)
    localparam int          DayShift   = 35;
    localparam logic [31:0] SecsPerDay = 32'd86400;
    // 2^31 + 951868800 = 35872 days + 11648 seconds
    localparam logic [16:0] DayBias    = 17'd35872;
    localparam logic [16:0] TodBias    = 17'd11648;
    localparam logic [16:0] TodWrap    = 17'd74752;     // 86400 - 11648

    localparam logic [17:0] Days400y   = 18'd146097;
    localparam logic [15:0] Days100y   = 16'd36524;
    localparam logic [15:0] Days4y     = 16'd1461;
    localparam logic [10:0] DaysYear   = 11'd365;
    localparam logic [15:0] Y4Recip    = 16'd45934;     // ceil(2^26 / 1461)
    localparam int          Y4Shift    = 26;

    // day offset, 3 more than a multiple of 7, that keeps the weekday sum positive
    localparam logic [15:0] WdBias     = 16'd35878;

    localparam logic [17:0] MinRecip   = 18'd139811;    // ceil(2^23 / 60)
    localparam int          MinShift   = 23;
    localparam logic [10:0] HourRecip  = 11'd1093;      // ceil(2^16 / 60)
    localparam int          HourShift  = 16;

    localparam logic [11:0] BaseYear   = 12'd2000;

    // first day of each month, counted from March 1
    function automatic logic [8:0] esc_month_start(input logic [3:0] mon);
        logic [8:0] res;
        case (mon)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/esc_split.sv
// ---------------------------------------------------------------------------
// esc_split
// Stages 1-2: splits the seconds count into whole days since 2000-03-01
// (floored) and seconds of the day.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_split
    import esc_pkg::*;
(
    input  wire                i_clk,
    input  t_pipe_ctl          i_ctl,
    input  wire  [31:0]        i_secs,
    output logic signed [16:0] o_days,
    output logic [16:0]        o_tod
);

    logic [31:0] w_u;
    logic [50:0] w_prod;
    logic [31:0] r1_u;
    logic [15:0] r1_q;
    logic [31:0] w_diff;
    logic [16:0] w_rem;
    logic [16:0] w_q_ext;
    logic signed [16:0] n_days;
    logic [16:0] n_tod;
    logic signed [16:0] r2_days;
    logic [16:0] r2_tod;

    // bias to unsigned, then floor(u / 86400) = floor((u >> 7) / 675)
    assign w_u    = {~i_secs[31], i_secs[30:0]};
    assign w_prod = 51'(w_u[31:7]) * 51'(DayRecip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r1_u <= w_u;
            r1_q <= w_prod[DayShift+15:DayShift];
        end
    end

    assign w_diff  = r1_u - (32'(r1_q) * SecsPerDay);
    assign w_rem   = w_diff[16:0];
    assign w_q_ext = 17'(r1_q);

    always_comb begin
        if (w_rem >= TodBias) begin
            n_days = $signed(w_q_ext - DayBias);
            n_tod  = w_rem - TodBias;
        end else begin
            n_days = $signed(w_q_ext - DayBias - 17'd1);
            n_tod  = w_rem + TodWrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r2_days <= n_days;
            r2_tod  <= n_tod;
        end
    end

    assign o_days = r2_days;
    assign o_tod  = r2_tod;

endmodule

`default_nettype wire

FILE: sv/esc_clock.sv
// ---------------------------------------------------------------------------
// esc_clock
// Stages 3-8: hour, minute and second from the seconds of the day.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_clock
    import esc_pkg::*;
(
    input  wire         i_clk,
    input  t_pipe_ctl   i_ctl,
    input  wire  [16:0] i_tod,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic [34:0] w_mprod;
    logic [16:0] r3_tod;
    logic [10:0] r3_mtot;
    logic [16:0] w_sdiff;
    logic [21:0] w_hprod;
    logic [5:0]  r4_sec;
    logic [10:0] r4_mtot;
    logic [4:0]  r4_hour;
    logic [10:0] w_mdiff;
    logic [16:0] r5_hms;
    logic [16:0] r6_hms;
    logic [16:0] r7_hms;
    logic [16:0] r8_hms;

    // total minutes of the day
    assign w_mprod = 35'(i_tod) * 35'(MinRecip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r3_tod  <= i_tod;
            r3_mtot <= w_mprod[MinShift+10:MinShift];
        end
    end

    assign w_sdiff = r3_tod - (17'(r3_mtot) * 17'd60);
    assign w_hprod = 22'(r3_mtot) * 22'(HourRecip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r4_sec  <= w_sdiff[5:0];
            r4_mtot <= r3_mtot;
            r4_hour <= w_hprod[HourShift+4:HourShift];
        end
    end

    assign w_mdiff = r4_mtot - (11'(r4_hour) * 11'd60);

    // packed hour, minute, second from here on, delayed to line up with the date
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[5]) begin
            r5_hms <= {r4_hour, w_mdiff[5:0], r4_sec};
        end
        if (i_ctl.adv[6]) begin
            r6_hms <= r5_hms;
        end
        if (i_ctl.adv[7]) begin
            r7_hms <= r6_hms;
        end
        if (i_ctl.adv[8]) begin
            r8_hms <= r7_hms;
        end
    end

    assign o_hour   = r8_hms[16:12];
    assign o_minute = r8_hms[11:6];
    assign o_second = r8_hms[5:0];

endmodule

`default_nettype wire

FILE: sv/esc_cal.sv
// ---------------------------------------------------------------------------
// esc_cal
// Stages 3-8: weekday, year, month, day and day of year from the day count
// since 2000-03-01.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_cal
    import esc_pkg::*;
(
    input  wire                i_clk,
    input  t_pipe_ctl          i_ctl,
    input  wire signed [16:0]  i_days,
    output logic [10:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic [2:0]         o_weekday,
    output logic [8:0]         o_day_of_year
);

    // stage 3
    logic [17:0] w_days_sx;
    logic [15:0] w_wx;
    logic [5:0]  w_ws1;
    logic [3:0]  w_ws2;
    logic [2:0]  n_wd;
    logic [17:0] n_rd3;
    logic [17:0] r3_rd;
    logic        r3_neg;
    logic [2:0]  r3_wd;
    // stage 4
    logic [1:0]  n_c100;
    logic [15:0] n_c100_days;
    logic [15:0] r4_rd;
    logic [1:0]  r4_c100;
    logic        r4_neg;
    logic [2:0]  r4_wd;
    // stage 5
    logic [31:0] w_y4prod;
    logic [15:0] r5_rd;
    logic [4:0]  r5_c4;
    logic [1:0]  r5_c100;
    logic        r5_neg;
    logic [2:0]  r5_wd;
    // stage 6
    logic [15:0] w_rd6;
    logic [10:0] r6_rd;
    logic [4:0]  r6_c4;
    logic [1:0]  r6_c100;
    logic        r6_neg;
    logic [2:0]  r6_wd;
    // stage 7
    logic [1:0]  n_c1;
    logic [10:0] n_c1_days;
    logic [10:0] w_rd7;
    logic [8:0]  n_c100_yrs;
    logic [8:0]  n_yoff;
    logic        n_leap;
    logic [8:0]  r7_rd;
    logic [8:0]  r7_yoff;
    logic        r7_leap;
    logic        r7_neg;
    logic [2:0]  r7_wd;
    // stage 8
    logic [3:0]  n_mon;
    logic [8:0]  w_mday;
    logic [9:0]  w_yday;
    logic [9:0]  w_ylen;
    logic [8:0]  n_yday;
    logic [3:0]  n_month;
    logic [11:0] n_year;
    logic [10:0] r8_year;
    logic [3:0]  r8_month;
    logic [4:0]  r8_day;
    logic [2:0]  r8_wd;
    logic [8:0]  r8_yday;

    // ---- stage 3: fold into one 400-year cycle, weekday
    assign w_days_sx = {i_days[16], i_days};
    assign n_rd3 = i_days[16] ? (w_days_sx + Days400y) : w_days_sx;

    // 8 = 1 mod 7, so summing octal digits keeps the residue
    assign w_wx  = w_days_sx[15:0] + WdBias;
    assign w_ws1 = 6'(w_wx[2:0]) + 6'(w_wx[5:3]) + 6'(w_wx[8:6])
                 + 6'(w_wx[11:9]) + 6'(w_wx[14:12]) + 6'(w_wx[15]);
    assign w_ws2 = 4'(w_ws1[5:3]) + 4'(w_ws1[2:0]);
    assign n_wd  = (w_ws2 >= 4'd7) ? 3'(w_ws2 - 4'd7) : w_ws2[2:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r3_rd  <= n_rd3;
            r3_neg <= i_days[16];
            r3_wd  <= n_wd;
        end
    end

    // ---- stage 4: centuries, the last one keeps the extra leap day
    always_comb begin
        if (r3_rd >= 18'(3 * Days100y)) begin
            n_c100      = 2'd3;
            n_c100_days = 16'(3 * Days100y);
        end else if (r3_rd >= 18'(2 * Days100y)) begin
            n_c100      = 2'd2;
            n_c100_days = 16'(2 * Days100y);
        end else if (r3_rd >= 18'(Days100y)) begin
            n_c100      = 2'd1;
            n_c100_days = Days100y;
        end else begin
            n_c100      = 2'd0;
            n_c100_days = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r4_rd   <= r3_rd[15:0] - n_c100_days;
            r4_c100 <= n_c100;
            r4_neg  <= r3_neg;
            r4_wd   <= r3_wd;
        end
    end

    // ---- stage 5: four-year groups
    assign w_y4prod = 32'(r4_rd) * 32'(Y4Recip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[5]) begin
            r5_rd   <= r4_rd;
            r5_c4   <= w_y4prod[Y4Shift+4:Y4Shift];
            r5_c100 <= r4_c100;
            r5_neg  <= r4_neg;
            r5_wd   <= r4_wd;
        end
    end

    // ---- stage 6: day within the four-year group
    assign w_rd6 = r5_rd - (16'(r5_c4) * Days4y);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[6]) begin
            r6_rd   <= w_rd6[10:0];
            r6_c4   <= r5_c4;
            r6_c100 <= r5_c100;
            r6_neg  <= r5_neg;
            r6_wd   <= r5_wd;
        end
    end

    // ---- stage 7: single years, the fourth keeps the leap day
    always_comb begin
        if (r6_rd >= 11'(3 * DaysYear)) begin
            n_c1      = 2'd3;
            n_c1_days = 11'(3 * DaysYear);
        end else if (r6_rd >= 11'(2 * DaysYear)) begin
            n_c1      = 2'd2;
            n_c1_days = 11'(2 * DaysYear);
        end else if (r6_rd >= DaysYear) begin
            n_c1      = 2'd1;
            n_c1_days = DaysYear;
        end else begin
            n_c1      = 2'd0;
            n_c1_days = 11'd0;
        end
    end

    always_comb begin
        case (r6_c100)
            2'd0:    n_c100_yrs = 9'd0;
            2'd1:    n_c100_yrs = 9'd100;
            2'd2:    n_c100_yrs = 9'd200;
            2'd3:    n_c100_yrs = 9'd300;
            default: n_c100_yrs = 9'd0;
        endcase
    end

    assign w_rd7  = r6_rd - n_c1_days;
    assign n_yoff = 9'(n_c1) + {2'b00, r6_c4, 2'b00} + n_c100_yrs;
    // the calendar year in which this March-based year starts holds Feb 29
    assign n_leap = (n_c1 == 2'd0) && ((r6_c4 != 5'd0) || (r6_c100 == 2'd0));

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[7]) begin
            r7_rd   <= w_rd7[8:0];
            r7_yoff <= n_yoff;
            r7_leap <= n_leap;
            r7_neg  <= r6_neg;
            r7_wd   <= r6_wd;
        end
    end

    // ---- stage 8: month lookup and final fields
    always_comb begin
        n_mon = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r7_rd >= esc_month_start(4'(m))) begin
                n_mon = n_mon + 4'd1;
            end
        end
    end

    assign w_mday = r7_rd - esc_month_start(n_mon) + 9'd1;
    assign w_yday = 10'(r7_rd) + 10'd59 + 10'(r7_leap);
    assign w_ylen = 10'd365 + 10'(r7_leap);
    assign n_yday = (w_yday >= w_ylen) ? 9'(w_yday - w_ylen) : w_yday[8:0];

    // january and february belong to the next calendar year
    always_comb begin
        n_year = BaseYear + 12'(r7_yoff) - (r7_neg ? 12'd400 : 12'd0);
        if (n_mon >= 4'd10) begin
            n_month = n_mon - 4'd9;
            n_year  = n_year + 12'd1;
        end else begin
            n_month = n_mon + 4'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[8]) begin
            r8_year  <= n_year[10:0];
            r8_month <= n_month;
            r8_day   <= w_mday[4:0];
            r8_wd    <= r7_wd;
            r8_yday  <= n_yday;
        end
    end

    assign o_year        = r8_year;
    assign o_month       = r8_month;
    assign o_day         = r8_day;
    assign o_weekday     = r8_wd;
    assign o_day_of_year = r8_yday;

endmodule

`default_nettype wire

FILE: sv/epoch_seconds_to_civil_date.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_civil_date
// Converts signed 32-bit seconds since 1970-01-01 UTC to Gregorian date,
// time of day, weekday and day of year. The converter is an 8-stage
// pipeline that takes one transaction per clock while the output side
// does not stall. The depth comes from the reciprocal multiplies for the
// day, four-year and minute splits, each followed by a register before
// its remainder multiply. Each stage holds its item until the next has
// room, so a stalled output backs up stage by stage and empty stages still
// fill behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_civil_date
    import esc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] epoch_seconds
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [10:0] year, [14:11] month, [19:15] day, [24:20] hour, [30:25] minute,
    // [36:31] second, [39:37] weekday, [48:40] day_of_year, [55:49] zero
    output logic [55:0] o_m_axis_tdata
);

`include "epoch_seconds_to_civil_date_assert.svh"

    logic [NumStages:1] r_v;
    logic [NumStages:1] n_v;
    t_pipe_ctl          w_ctl;
    logic signed [16:0] w_days;
    logic [16:0]        w_tod;
    logic [10:0]        w_year;
    logic [3:0]         w_month;
    logic [4:0]         w_day;
    logic [4:0]         w_hour;
    logic [5:0]         w_minute;
    logic [5:0]         w_second;
    logic [2:0]         w_weekday;
    logic [8:0]         w_day_of_year;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        w_ctl.adv[NumStages] = !r_v[NumStages] || i_m_axis_tready;
        for (int k = NumStages - 1; k >= 1; k--) begin
            w_ctl.adv[k] = !r_v[k] || w_ctl.adv[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_ctl.adv[1]) begin
            n_v[1] = i_s_axis_tvalid;
        end
        for (int k = 2; k <= NumStages; k++) begin
            if (w_ctl.adv[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    esc_split u_split (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_secs (i_s_axis_tdata),
        .o_days (w_days),
        .o_tod  (w_tod)
    );

    esc_clock u_clock (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_tod    (w_tod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    esc_cal u_cal (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_days        (w_days),
        .o_year        (w_year),
        .o_month       (w_month),
        .o_day         (w_day),
        .o_weekday     (w_weekday),
        .o_day_of_year (w_day_of_year)
    );

    assign o_s_axis_tready = w_ctl.adv[1];
    assign o_m_axis_tvalid = r_v[NumStages];
    assign o_m_axis_tdata  = {7'd0, w_day_of_year, w_weekday, w_second, w_minute,
                              w_hour, w_day, w_month, w_year};

    // an accepted transaction always lands in the first stage
    `ESC_ASSERT_NEXT(a_accept_fills, (i_s_axis_tvalid && o_s_axis_tready), (r_v[1]), "accepted transaction lost at stage 1")
    `ESC_ASSERT_ALWAYS(a_date_range, (!o_m_axis_tvalid || (w_month >= 4'd1 && w_month <= 4'd12 && w_day >= 5'd1 && w_day <= 5'd31)), "month or day out of range")
    `ESC_ASSERT_ALWAYS(a_clock_range, (!o_m_axis_tvalid || (w_hour < 5'd24 && w_minute < 6'd60 && w_second < 6'd60)), "time of day out of range")
    `ESC_ASSERT_ALWAYS(a_week_year_range, (!o_m_axis_tvalid || (w_weekday < 3'd7 && w_day_of_year <= 9'd365 && w_year >= 11'd1901 && w_year <= 11'd2038)), "weekday, day of year or year out of range")

endmodule

`default_nettype wire
